// ===== src/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_pkg - shared definitions for the DDA line rasteriser
// Default widths, item command codes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package dlr_pkg;

    // default coordinate width and fixed-point fraction width
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // item command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // per-cycle command from controller to datapath
    typedef struct packed {
        logic load;      // capture endpoints, start division
        logic div_step;  // one restoring-division iteration
        logic finish;    // apply signs, commit increments
        logic advance;   // emit current pixel, step the point
    } t_dp_cmd;

endpackage

// ===== src/dlr_ifs.sv =====
// ----------------------------------------------------------------------------
// dlr_ifs - valid/ready channels of the DDA line rasteriser
// Line item channel (commands and endpoints) and pixel result channel.
// ----------------------------------------------------------------------------
interface dlr_line_if #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dlr_pixel_if #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         valid_res;
    logic                         last;

    modport source (output valid, pixel_x, pixel_y, valid_res, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, valid_res, last, output ready);
endinterface

// ===== src/dlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlr_ctrl - controller of the DDA line rasteriser
// Sequences the increment division after a load and owns the result valid.
// ----------------------------------------------------------------------------
module dlr_ctrl #(
    parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_cmd,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output dlr_pkg::t_dp_cmd o_cmd
);
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(FRAC_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic            w_accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_accept && (i_in_cmd == dlr_pkg::CMD_LOAD);
        o_cmd.advance  = w_accept && (i_in_cmd == dlr_pkg::CMD_ADVANCE);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.finish   = (r_state == S_FIN);
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (o_cmd.advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == LAST_CNT) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/dlr_dp.sv =====
// ----------------------------------------------------------------------------
// dlr_dp - datapath of the DDA line rasteriser
// Endpoint deltas, two restoring dividers, point accumulators, result register.
// ----------------------------------------------------------------------------
module dlr_dp #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dlr_pkg::t_dp_cmd             i_cmd,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_valid_res,
    output logic                         o_last
);
    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = C + F;   // current point width
    localparam int SW = F + 2;   // signed increment width

    // load-time deltas
    logic signed [C:0]   w_dx, w_dy;
    logic [C-1:0]        w_adx, w_ady, w_steps;

    // division state
    logic [C-1:0]        r_steps;
    logic [C:0]          r_rem_x, r_rem_y;
    logic [F:0]          r_q_x, r_q_y;
    logic                r_neg_x, r_neg_y;
    logic                w_ge_x, w_ge_y;
    logic [C:0]          w_sel_x, w_sel_y;

    // line state
    logic signed [PW-1:0] r_cur_x, r_cur_y;
    logic signed [SW-1:0] r_inc_x, r_inc_y;
    logic [C-1:0]         r_left;

    // pixel extraction, truncation toward zero
    logic signed [C-1:0]  w_pix_x, w_pix_y;

    assign w_dx    = {i_end_x[C-1], i_end_x} - {i_start_x[C-1], i_start_x};
    assign w_dy    = {i_end_y[C-1], i_end_y} - {i_start_y[C-1], i_start_y};
    assign w_adx   = w_dx[C] ? C'(-w_dx) : w_dx[C-1:0];
    assign w_ady   = w_dy[C] ? C'(-w_dy) : w_dy[C-1:0];
    assign w_steps = (w_adx > w_ady) ? w_adx : w_ady;

    // remainder stays below the divisor, so the doubled value fits C+1 bits
    assign w_ge_x  = r_rem_x >= {1'b0, r_steps};
    assign w_ge_y  = r_rem_y >= {1'b0, r_steps};
    assign w_sel_x = w_ge_x ? (r_rem_x - {1'b0, r_steps}) : r_rem_x;
    assign w_sel_y = w_ge_y ? (r_rem_y - {1'b0, r_steps}) : r_rem_y;

    assign w_pix_x = r_cur_x[PW-1:F] + C'(r_cur_x[PW-1] && (|r_cur_x[F-1:0]));
    assign w_pix_y = r_cur_y[PW-1:F] + C'(r_cur_y[PW-1] && (|r_cur_y[F-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_cmd.load) begin
            r_left <= w_steps;
        end else if (i_cmd.advance && (r_left != '0)) begin
            r_left <= r_left - C'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_steps <= w_steps;
            r_rem_x <= {1'b0, w_adx};
            r_rem_y <= {1'b0, w_ady};
            r_q_x   <= '0;
            r_q_y   <= '0;
            r_neg_x <= w_dx[C];
            r_neg_y <= w_dy[C];
            r_cur_x <= {i_start_x, {F{1'b0}}};
            r_cur_y <= {i_start_y, {F{1'b0}}};
        end else if (i_cmd.advance && (r_left != '0)) begin
            r_cur_x <= r_cur_x + {{(PW-SW){r_inc_x[SW-1]}}, r_inc_x};
            r_cur_y <= r_cur_y + {{(PW-SW){r_inc_y[SW-1]}}, r_inc_y};
        end
        if (i_cmd.div_step) begin
            r_q_x   <= {r_q_x[F-1:0], w_ge_x};
            r_q_y   <= {r_q_y[F-1:0], w_ge_y};
            r_rem_x <= {w_sel_x[C-1:0], 1'b0};
            r_rem_y <= {w_sel_y[C-1:0], 1'b0};
        end
        if (i_cmd.finish) begin
            // zero-length line: divider result is meaningless, force zero
            if (r_steps == '0) begin
                r_inc_x <= '0;
                r_inc_y <= '0;
            end else begin
                r_inc_x <= r_neg_x ? -$signed({1'b0, r_q_x}) : $signed({1'b0, r_q_x});
                r_inc_y <= r_neg_y ? -$signed({1'b0, r_q_y}) : $signed({1'b0, r_q_y});
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            if (r_left != '0) begin
                o_pixel_x   <= w_pix_x;
                o_pixel_y   <= w_pix_y;
                o_valid_res <= 1'b1;
                o_last      <= (r_left == C'(1));
            end else begin
                o_pixel_x   <= '0;
                o_pixel_y   <= '0;
                o_valid_res <= 1'b0;
                o_last      <= 1'b0;
            end
        end
    end

endmodule

// ===== src/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer - DDA line rasteriser, top level
// Load a line from two endpoints, then request its pixels one at a time.
// ----------------------------------------------------------------------------
// A load item (cmd 0) takes the endpoints and produces no result; the block
// then works out both increments with restoring dividers giving one quotient
// bit per cycle, and takes no new item until the division and its finishing
// step are done. An advance item (cmd 1) yields one result carrying the
// current point, truncated toward zero, and steps the point by one
// fixed-point add per axis. Exactly max(|dx|, |dy|) pixels are given per
// line, the end point being excluded; an advance with nothing pending yields
// a result with valid_res low and all other fields zero. A load during a
// line abandons it. The result sits in an output register, so a new item is
// taken in the same cycle that the waiting result is transferred.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dlr_line_if.sink     i_line,
    dlr_pixel_if.source  o_pixel
);
    dlr_pkg::t_dp_cmd w_cmd;

    // sequencing: division iterations, input ready, result valid
    dlr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .i_in_cmd    (i_line.cmd),
        .o_in_ready  (i_line.ready),
        .i_out_ready (o_pixel.ready),
        .o_out_valid (o_pixel.valid),
        .o_cmd       (w_cmd)
    );

    // arithmetic and line state
    dlr_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_start_x   (i_line.start_x),
        .i_start_y   (i_line.start_y),
        .i_end_x     (i_line.end_x),
        .i_end_y     (i_line.end_y),
        .o_pixel_x   (o_pixel.pixel_x),
        .o_pixel_y   (o_pixel.pixel_y),
        .o_valid_res (o_pixel.valid_res),
        .o_last      (o_pixel.last)
    );

    // no item taken while the divider runs
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.div_step || w_cmd.finish) |-> !i_line.ready)
        else $error("item accepted during increment division");

    // a load starts the divider on the next cycle
    a_load_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> w_cmd.div_step)
        else $error("load not followed by division");

    // every advance leaves a result waiting
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.advance |=> o_pixel.valid)
        else $error("advance transfer produced no result");

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.div_step, w_cmd.finish, w_cmd.advance}))
        else $error("conflicting datapath commands");

endmodule

// ===== test/dda_line_rasterizer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_checker - pixel predictor and result comparison
// Watches both channels, tracks the line state for every item transfer and
// compares each pixel transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dlr_line_if   i_line,
    dlr_pixel_if  i_pixel,
    output int    o_fail_count,
    output int    o_pixels_owed
);
    localparam int CB    = dlr_pkg::COORD_BITS_DEF;
    localparam int FB    = dlr_pkg::FRAC_BITS_DEF;
    localparam int POS_W = CB + FB + 1;
    localparam int INC_W = FB + 2;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 given;
        logic                 last;
    } t_pixel;

    // predicted line state
    logic signed [POS_W-1:0] pen_x_fx;
    logic signed [POS_W-1:0] pen_y_fx;
    logic signed [INC_W-1:0] inc_x_fx;
    logic signed [INC_W-1:0] inc_y_fx;
    logic        [CB:0]      pixels_left;

    t_pixel owed_q[$];
    int     mismatches = 0;

    // per-pixel increment: delta / span with FB fraction bits, toward zero
    function automatic logic signed [INC_W-1:0] line_increment(input int delta, input int span);
        logic signed [63:0] mag;
        mag = 0;
        if (span != 0)
            mag = (64'(delta < 0 ? -delta : delta) << FB) / span;
        if (delta < 0)
            mag = -mag;
        return mag[INC_W-1:0];
    endfunction

    function automatic logic signed [CB-1:0] fx_to_coord(input logic signed [POS_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        w = (w < 0) ? -((-w) >>> FB) : (w >>> FB);
        return w[CB-1:0];
    endfunction

    task automatic track_item(input logic op,
                              input logic signed [CB-1:0] sx, sy, ex, ey);
        int     dx, dy, span;
        t_pixel want;
        if (op == dlr_pkg::CMD_LOAD) begin
            dx   = int'(ex) - int'(sx);
            dy   = int'(ey) - int'(sy);
            dx   = (dx < 0) ? -dx : dx;
            dy   = (dy < 0) ? -dy : dy;
            span = (dx > dy) ? dx : dy;
            inc_x_fx    = line_increment(int'(ex) - int'(sx), span);
            inc_y_fx    = line_increment(int'(ey) - int'(sy), span);
            pen_x_fx    = POS_W'(sx);
            pen_y_fx    = POS_W'(sy);
            pen_x_fx    = pen_x_fx <<< FB;
            pen_y_fx    = pen_y_fx <<< FB;
            pixels_left = span[CB:0];
        end else if (pixels_left == 0) begin
            want = '0;
            owed_q.push_back(want);
        end else begin
            want.x     = fx_to_coord(pen_x_fx);
            want.y     = fx_to_coord(pen_y_fx);
            want.given = 1'b1;
            want.last  = (pixels_left == 1);
            owed_q.push_back(want);
            pen_x_fx    = pen_x_fx + inc_x_fx;
            pen_y_fx    = pen_y_fx + inc_y_fx;
            pixels_left = pixels_left - (CB+1)'(1);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (owed_q.size() == 0) begin
            $error("pixel transfer with nothing expected: x %0d y %0d",
                   i_pixel.pixel_x, i_pixel.pixel_y);
            mismatches++;
        end else begin
            want = owed_q.pop_front();
            compare_field("pixel_x", int'($signed(want.x)), int'(i_pixel.pixel_x));
            compare_field("pixel_y", int'($signed(want.y)), int'(i_pixel.pixel_y));
            compare_field("valid_res", int'(want.given), int'(i_pixel.valid_res));
            compare_field("last", int'(want.last), int'(i_pixel.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pen_x_fx    = '0;
            pen_y_fx    = '0;
            inc_x_fx    = '0;
            inc_y_fx    = '0;
            pixels_left = '0;
            owed_q.delete();
        end else begin
            // a result never leaves in the cycle its item arrives
            if (i_pixel.valid && i_pixel.ready)
                check_pixel();
            if (i_line.valid && i_line.ready)
                track_item(i_line.cmd, i_line.start_x, i_line.start_y,
                           i_line.end_x, i_line.end_y);
        end
        o_pixels_owed <= owed_q.size();
        o_fail_count  <= mismatches;
    end

endmodule

// ===== test/dda_line_rasterizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb - testbench top for the DDA line rasteriser
// Drives line loads and pixel requests with random gaps and result stalls;
// the checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;

    localparam int CB          = dlr_pkg::COORD_BITS_DEF;
    localparam int COORD_MIN   = -(1 << (CB - 1));
    localparam int COORD_MAX   = (1 << (CB - 1)) - 1;
    localparam int TOTAL_ITEMS = 575;      // directed part plus about 550 random
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;       // covers the divider's busy time after a load

    logic i_clk;
    logic i_rst_n;

    dlr_line_if  line_ch ();
    dlr_pixel_if pixel_ch ();

    int  fail_count;
    int  pixels_owed;
    int  cycle_count;
    int  loads_sent    = 0;
    int  advances_sent = 0;
    int  long_lines    = 0;
    int  pauses        = 0;
    bit  send_calm     = 1'b0;
    bit  take_calm     = 1'b0;
    bit  mid_pause     = 1'b0;

    dda_line_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_ch),
        .o_pixel (pixel_ch)
    );

    dda_line_rasterizer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line        (line_ch),
        .i_pixel       (pixel_ch),
        .o_fail_count  (fail_count),
        .o_pixels_owed (pixels_owed)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Item side. Each transfer is preceded by a random gap with valid low;
    // now and then the gaps switch off for a stretch so back-to-back
    // transfers occur too. The task returns at the edge of the transfer,
    // so a following item with no gap keeps valid high without a glitch.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op,
                             input logic signed [CB-1:0] sx, sy, ex, ey);
        int gap;
        if ($urandom_range(0, 24) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            line_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        line_ch.valid   <= 1'b1;
        line_ch.cmd     <= op;
        line_ch.start_x <= sx;
        line_ch.start_y <= sy;
        line_ch.end_x   <= ex;
        line_ch.end_y   <= ey;
        @(posedge i_clk);
        while (!line_ch.ready) @(posedge i_clk);
        if (op == dlr_pkg::CMD_LOAD)
            loads_sent++;
        else
            advances_sent++;
    endtask

    task automatic load_line(input int sx, input int sy, input int ex, input int ey);
        send_item(dlr_pkg::CMD_LOAD, CB'(sx), CB'(sy), CB'(ex), CB'(ey));
    endtask

    // endpoint fields are don't-care on an advance, so fill them with noise
    task automatic request_pixels(input int count);
        repeat (count)
            send_item(dlr_pkg::CMD_ADVANCE, CB'($urandom), CB'($urandom),
                      CB'($urandom), CB'($urandom));
    endtask

    // stop sending until every predicted pixel has been transferred; the
    // first edge lets the owed count catch up with a transfer just made
    task automatic hold_until_drained();
        line_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pixels_owed != 0) @(posedge i_clk);
        pauses++;
    endtask

    function automatic int pick_near(input int centre, input int reach);
        int lo, hi;
        lo = (centre - reach < COORD_MIN) ? COORD_MIN : centre - reach;
        hi = (centre + reach > COORD_MAX) ? COORD_MAX : centre + reach;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // A line with random start anywhere on the grid. Most are short and
    // walked to the end (sometimes one request past it); some are cut short
    // and replaced by the next load; long ones are always abandoned early.
    task automatic random_line();
        int sx, sy, ex, ey, reach, dx, dy, steps, count, pick;
        sx = $signed(CB'($urandom));
        sy = $signed(CB'($urandom));
        case ($urandom_range(0, 19))
            0, 1:    reach = 1 << CB;
            2, 3:    reach = $urandom_range(13, 300);
            default: reach = $urandom_range(0, 12);
        endcase
        ex    = pick_near(sx, reach);
        ey    = pick_near(sy, reach);
        dx    = (ex > sx) ? ex - sx : sx - ex;
        dy    = (ey > sy) ? ey - sy : sy - ey;
        steps = (dx > dy) ? dx : dy;
        pick  = $urandom_range(0, 9);
        if (steps > 400)
            count = $urandom_range(0, 40);
        else if (pick < 7)
            count = steps + $urandom_range(0, 1);
        else if (pick < 9)
            count = $urandom_range(0, steps);
        else
            count = 0;
        // keep the item total close to its target
        if (count > TOTAL_ITEMS - (loads_sent + advances_sent) - 1)
            count = TOTAL_ITEMS - (loads_sent + advances_sent) - 1;
        if (count >= 40)
            long_lines++;
        load_line(sx, sy, ex, ey);
        request_pixels(count);
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready held low for a random stall, then high until the
    // next pixel transfer. Stalls also switch off for stretches.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        pixel_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 24) == 0)
                take_calm = !take_calm;
            stall = take_calm ? 0 : $urandom_range(0, 18);
            if (stall != 0) begin
                pixel_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pixel_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!pixel_ch.valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        line_ch.valid   <= 1'b0;
        line_ch.cmd     <= dlr_pkg::CMD_LOAD;
        line_ch.start_x <= '0;
        line_ch.start_y <= '0;
        line_ch.end_x   <= '0;
        line_ch.end_y   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // request straight out of reset: nothing pending, empty result
        request_pixels(1);
        // zero-length line in a grid corner: still nothing pending
        load_line(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        request_pixels(1);
        // corner-to-corner diagonal, unit increments, abandoned mid-line
        load_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        request_pixels(3);
        // the other diagonal, x running negative, replaces it
        load_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        request_pixels(2);
        // fractional negative steps: truncation toward zero, one past the end
        load_line(0, 0, -3, -7);
        request_pixels(8);
        // one-pixel line: first pixel is also the last
        load_line(0, 0, 1, -1);
        request_pixels(2);
        // vertical line on the bottom edge of the grid
        load_line(3, COORD_MIN, 3, COORD_MIN + 3);
        request_pixels(4);
        hold_until_drained();

        while (loads_sent + advances_sent < TOTAL_ITEMS) begin
            if (!mid_pause && loads_sent + advances_sent > TOTAL_ITEMS / 2) begin
                mid_pause = 1'b1;
                hold_until_drained();
            end
            if ($urandom_range(0, 9) == 0)
                request_pixels(1);      // stray request, often with no line pending
            else
                random_line();
        end

        hold_until_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d line loads and %0d pixel requests, %0d runs of 40+ pixels,",
                 loads_sent, advances_sent, long_lines);
        $display("with %0d full drains and random gaps and stalls on both channels",
                 pauses);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== dda_line_rasterizer.f =====
src/dlr_pkg.sv
src/dlr_ifs.sv
src/dlr_ctrl.sv
src/dlr_dp.sv
src/dda_line_rasterizer.sv
test/dda_line_rasterizer_checker.sv
test/dda_line_rasterizer_tb.sv
